/* rtl/core/vitk5_pkg.sv */
// Package for the K=5 rate-1/4 Viterbi decoder: state codes, generators and helpers.
// No dependencies.
`default_nettype none
package vitk5_pkg;

  localparam int unsigned NSTATES    = 16;
  localparam int unsigned METRIC_W   = 20;
  localparam logic [19:0] METRIC_MAX = 20'hFFFFF;
  localparam int unsigned MAX_WORDS  = 8;

  localparam logic [4:0] GEN_A = 5'h13;
  localparam logic [4:0] GEN_B = 5'h1D;
  localparam logic [4:0] GEN_C = 5'h17;
  localparam logic [4:0] GEN_D = 5'h1B;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACS,
    ST_COMMIT,
    ST_TB_RD,
    ST_TB_STEP,
    ST_EMIT
  } state_e;

  // Expected code bit: parity of the masked shift register.
  function automatic logic par5(input logic [4:0] sr, input logic [4:0] gen);
    par5 = ^(sr & gen);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/viterbi_decoder_k5_r14_unit.sv */
// Top level of the K=5 rate-1/4 Viterbi decoder with one shared ACS unit and traceback.
// Depends on vitk5_pkg and vitk5_bm.
//
//  channel | dir | beat contents
//  s_axis  | in  | tdata: sym_a..sym_d, tlast: last_stage
//  m_axis  | out | tdata: bits_word, word_index, valid_bits, tlast: last_word
//  cfg     | in  | metric_mode
//
// Each stage runs one ACS step per state on the shared unit, then a commit.
// A last stage adds one survivor memory read per stored stage for traceback,
// then the words are sent, held by any output stall. Reset is asynchronous; no clearing pass.
// The input is not ready while a stage, traceback or output is under way.
`default_nettype none
module viterbi_decoder_k5_r14_unit #(
  parameter int unsigned MAX_STAGES = 512,
  parameter int unsigned SOFT_WIDTH = 8,
  parameter int unsigned WORD_BITS  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sym_a, sym_b, sym_c, sym_d
  input  wire logic        s_axis_tlast,   // last_stage
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // bits_word[63:0], word_index, valid_bits, pad
  output logic             m_axis_tlast    // last_word
);

  localparam int unsigned AW  = $clog2(MAX_STAGES);
  localparam int unsigned CW  = $clog2(MAX_STAGES + 1);
  localparam int unsigned BW  = $clog2(WORD_BITS);
  localparam int unsigned BMW = SOFT_WIDTH + 2;

  vitk5_pkg::state_e state_q, state_d;

  logic              mode_q;
  logic [31:0]       syms_q;
  logic              last_q;
  logic [19:0]       pm_q [16];
  logic [19:0]       nm_q [16];
  logic [15:0]       reach_q, nr_q, dec_q;
  logic [3:0]        ns_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     tb_q;
  logic [3:0]        st_q;
  logic [15:0]       mem [MAX_STAGES];
  logic [15:0]       rd_q;
  logic [WORD_BITS-1:0] dbits [8];
  logic [2:0]        w_q;
  logic [3:0]        nw;

  // Shared ACS: two branch metrics for current state
  logic [BMW-1:0] bm0, bm1;
  logic [20:0]    s0, s1;
  logic [19:0]    m0, m1;
  logic [3:0]     p0, p1;
  logic           r0, r1, pick1;

  assign p0 = {1'b0, ns_q[3:1]};
  assign p1 = {1'b1, ns_q[3:1]};

  vitk5_bm #(.SOFT_WIDTH(SOFT_WIDTH)) u_bm0 (
    .soft_i(mode_q), .sr_i({1'b0, ns_q}), .syms_i(syms_q), .bm_o(bm0));
  vitk5_bm #(.SOFT_WIDTH(SOFT_WIDTH)) u_bm1 (
    .soft_i(mode_q), .sr_i({1'b1, ns_q}), .syms_i(syms_q), .bm_o(bm1));

  always_comb begin
    r0 = reach_q[p0];
    r1 = reach_q[p1];
    s0 = 21'(pm_q[p0]) + 21'(bm0);
    s1 = 21'(pm_q[p1]) + 21'(bm1);
    m0 = s0[20] ? vitk5_pkg::METRIC_MAX : s0[19:0];
    m1 = s1[20] ? vitk5_pkg::METRIC_MAX : s1[19:0];
    pick1 = r1 && (!r0 || m1 < m0);
  end

  // Number of words to send
  always_comb begin
    logic [CW:0] t;
    t  = ((CW+1)'(cnt_q) + (CW+1)'(WORD_BITS - 1)) >> BW;
    nw = (t > (CW+1)'(8)) ? 4'd8 : 4'(t);
  end

  wire in_acc  = s_axis_tvalid && s_axis_tready;
  wire out_acc = m_axis_tvalid && m_axis_tready;
  wire full    = cnt_q == CW'(MAX_STAGES);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vitk5_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!full) state_d = vitk5_pkg::ST_ACS;
          else if (s_axis_tlast) state_d = vitk5_pkg::ST_TB_RD;
        end
      end
      vitk5_pkg::ST_ACS:     if (ns_q == 4'd15) state_d = vitk5_pkg::ST_COMMIT;
      vitk5_pkg::ST_COMMIT:  state_d = last_q ? vitk5_pkg::ST_TB_RD : vitk5_pkg::ST_IDLE;
      vitk5_pkg::ST_TB_RD:   state_d = (tb_q == '0) ? vitk5_pkg::ST_EMIT
                                                    : vitk5_pkg::ST_TB_STEP;
      vitk5_pkg::ST_TB_STEP: state_d = vitk5_pkg::ST_TB_RD;
      vitk5_pkg::ST_EMIT: begin
        if (nw == 4'd0 || (out_acc && 4'(w_q) + 4'd1 == nw)) state_d = vitk5_pkg::ST_IDLE;
      end
      default: state_d = vitk5_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = state_q == vitk5_pkg::ST_IDLE;
    m_axis_tvalid = state_q == vitk5_pkg::ST_EMIT && nw != 4'd0;
  end

  always_comb begin
    logic [CW:0] base, rem;
    base = (CW+1)'(w_q) << BW;
    rem  = (CW+1)'(cnt_q) - base;
    if (rem > (CW+1)'(WORD_BITS)) rem = (CW+1)'(WORD_BITS);
    m_axis_tdata        = '0;
    m_axis_tdata[63:0]  = 64'(dbits[w_q]);
    m_axis_tdata[66:64] = w_q;
    m_axis_tdata[73:67] = 7'(rem);
    m_axis_tlast        = 4'(w_q) + 4'd1 == nw;
  end

  // Survivor store
  always_ff @(posedge clk_i) begin
    if (state_q == vitk5_pkg::ST_COMMIT && !full) mem[cnt_q[AW-1:0]] <= dec_q;
    if (state_q == vitk5_pkg::ST_TB_RD && tb_q != '0) rd_q <= mem[AW'(tb_q - 1'b1)];
  end

  // Decoded bits, one per traceback step; clear the buffer once all words are sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [CW-1:0] k;
    k = tb_q - 1'b1;
    if (!rst_ni) begin
      for (int w = 0; w < 8; w++) dbits[w] <= '0;
    end else if (state_q == vitk5_pkg::ST_TB_STEP) begin
      if ((k >> BW) < CW'(8)) dbits[3'(k >> BW)][BW'(k)] <= st_q[0];
    end else if (state_q == vitk5_pkg::ST_EMIT && state_d == vitk5_pkg::ST_IDLE) begin
      for (int w = 0; w < 8; w++) dbits[w] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vitk5_pkg::ST_IDLE;
      mode_q  <= 1'b0;
      reach_q <= 16'h0001;
      cnt_q   <= '0;
      ns_q    <= '0;
      tb_q    <= '0;
      st_q    <= '0;
      w_q     <= '0;
      last_q  <= 1'b0;
      for (int s = 0; s < 16; s++) pm_q[s] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      unique case (state_q)
        vitk5_pkg::ST_IDLE: begin
          ns_q <= '0;
          w_q  <= '0;
          st_q <= '0;
          tb_q <= cnt_q;
          if (in_acc) begin
            syms_q <= s_axis_tdata;
            last_q <= s_axis_tlast;
          end
        end
        vitk5_pkg::ST_ACS: begin
          nr_q[ns_q]  <= r0 || r1;
          dec_q[ns_q] <= pick1;
          nm_q[ns_q]  <= pick1 ? m1 : (r0 ? m0 : '0);
          ns_q        <= ns_q + 4'd1;
        end
        vitk5_pkg::ST_COMMIT: begin
          for (int s = 0; s < 16; s++) pm_q[s] <= nm_q[s];
          reach_q <= nr_q;
          cnt_q   <= cnt_q + 1'b1;
          tb_q    <= cnt_q + 1'b1;
        end
        vitk5_pkg::ST_TB_STEP: begin
          st_q <= {rd_q[st_q], st_q[3:1]};
          tb_q <= tb_q - 1'b1;
        end
        vitk5_pkg::ST_EMIT: begin
          if (out_acc) w_q <= w_q + 3'd1;
          // Clear block state once all words are sent
          if (state_d == vitk5_pkg::ST_IDLE) begin
            cnt_q   <= '0;
            reach_q <= 16'h0001;
            for (int s = 0; s < 16; s++) pm_q[s] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/vitk5_bm.sv */
// Branch metric unit: cost of one stage's four symbols against one shift-register value.
// Depends on vitk5_pkg.
`default_nettype none
module vitk5_bm #(
  parameter int unsigned SOFT_WIDTH = 8
) (
  input  wire logic              soft_i,
  input  wire logic [4:0]        sr_i,
  input  wire logic [31:0]       syms_i,
  output logic      [SOFT_WIDTH+1:0] bm_o
);

  localparam logic [15:0] Lim = 16'(1 << (SOFT_WIDTH - 1));

  logic [4:0] gens [4];
  logic [SOFT_WIDTH-1:0] cost [4];

  assign gens[0] = vitk5_pkg::GEN_A;
  assign gens[1] = vitk5_pkg::GEN_B;
  assign gens[2] = vitk5_pkg::GEN_C;
  assign gens[3] = vitk5_pkg::GEN_D;

  // Cost per symbol, hard or soft
  always_comb begin
    logic [7:0] v;
    logic [7:0] mag;
    logic       exp_b;
    for (int m = 0; m < 4; m++) begin
      v     = syms_i[8*m +: 8];
      exp_b = vitk5_pkg::par5(sr_i, gens[m]);
      mag   = v[7] ? 8'(-v) : v;
      if (v == 8'h80) mag = 8'h80;
      if (16'(mag) > Lim) mag = 8'(Lim);
      cost[m] = '0;
      if (!soft_i) begin
        if (v != 8'd2 && v[0] != exp_b) cost[m] = SOFT_WIDTH'(1);
      end else begin
        if (v != 8'd0 && (!v[7]) != exp_b) cost[m] = SOFT_WIDTH'(mag);
      end
    end
  end

  assign bm_o = (SOFT_WIDTH+2)'(cost[0]) + (SOFT_WIDTH+2)'(cost[1])
              + (SOFT_WIDTH+2)'(cost[2]) + (SOFT_WIDTH+2)'(cost[3]);

endmodule
`default_nettype wire

/* rtl/core/vitk5_chk.sv */
// Port-level checker for the Viterbi decoder, bound to the top level.
// Depends on viterbi_decoder_k5_r14_unit.
`default_nettype none
module vitk5_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input ready while emitting");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped");

  a_vbits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[73:67] != 7'd0) else $error("empty word");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("beat after last word");

endmodule

bind viterbi_decoder_k5_r14_unit vitk5_chk u_chk (.*);
`default_nettype wire
